/* rtl/core/rdm_pkg.sv */
// Shared widths, latencies and register indexes for the radial distortion map.
package rdm_pkg;

    // Field and register widths.
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int COEF_W  = 16;
    localparam int NORM_W  = 16;
    localparam int OUT_W   = 16;
    localparam int DATA_W  = 16;
    localparam int IDX_W   = 3;

    // Internal fixed-point widths.
    localparam int SQ_W    = 31;   // x*x, at most 2^30
    localparam int R2_W    = 17;   // Q2.15, at most 2.0
    localparam int R4_W    = 18;   // Q3.15, at most 4.0
    localparam int K1R2_W  = COEF_W + R2_W + 1;
    localparam int K2R4_W  = COEF_W + R4_W + 1;
    localparam int SCALE_W = 36;   // Q.29 scale with headroom
    localparam int PROD_W  = NORM_W + SCALE_W;
    localparam int T_W     = PROD_W + DIM_W + 1;

    // Divider layout: one quotient bit per step, a few steps per stage.
    localparam int REM_W      = DIM_W;
    localparam int Q_W        = NORM_W;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = Q_W / DIV_STEPS;

    // Pipeline depth of each section.
    localparam int NORM_LAT  = DIV_STAGES + 3;
    localparam int SCALE_LAT = 5;
    localparam int REMAP_LAT = 3;
    localparam int LATENCY   = NORM_LAT + SCALE_LAT + REMAP_LAT;

    // Fixed-point anchors.
    localparam int SCALE_FRAC = 29;
    localparam int R_FRAC     = 15;
    localparam int HALF_EXP   = 44;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        CFG_IMAGE_ROWS      = 3'd0,
        CFG_IMAGE_COLS      = 3'd1,
        CFG_K1_COEFF        = 3'd2,
        CFG_K2_COEFF        = 3'd3,
        CFG_PINCUSHION_MODE = 3'd4
    } cfg_idx_t;

    // Pipeline control shared by all sections.
    typedef struct packed {
        logic en;
    } pipe_ctrl_t;

endpackage

/* rtl/core/rdm_normalize.sv */
// Normalizes one pixel index to signed Q1.15 through a pipelined divider.
module rdm_normalize (
    input  logic                                clk,
    input  rdm_pkg::pipe_ctrl_t                 ctrl,
    input  logic [rdm_pkg::COORD_W-1:0]         pos,
    input  logic [rdm_pkg::DIM_W-1:0]           dim,
    output logic signed [rdm_pkg::NORM_W-1:0]   norm
);
    import rdm_pkg::*;

    logic [COORD_W-1:0] pos_reg;
    logic [DIM_W-1:0]   two_pos;
    logic               sat_next;
    logic               neg_next;
    logic [REM_W-1:0]   mag_next;
    logic               sat_reg;
    logic               neg_reg;
    logic [REM_W-1:0]   mag_reg;

    logic [REM_W-1:0] rem_reg [DIV_STAGES];
    logic [Q_W-1:0]   quo_reg [DIV_STAGES];
    logic             dsat_reg [DIV_STAGES];
    logic             dneg_reg [DIV_STAGES];

    logic signed [NORM_W-1:0] norm_next;
    logic signed [NORM_W-1:0] norm_reg;

    // Input register: the index is held before any configuration is read.
    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            pos_reg <= pos;
        end
    end

    // Signed numerator 2*pos - dim as sign and magnitude, plus the clip case.
    assign two_pos  = {pos_reg, 1'b0};
    assign sat_next = ({1'b0, pos_reg} >= dim);
    assign neg_next = (two_pos < dim);
    assign mag_next = neg_next ? (dim - two_pos) : (two_pos - dim);

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            sat_reg <= sat_next;
            neg_reg <= neg_next;
            mag_reg <= mag_next;
        end
    end

    // Restoring divider: magnitude * 2^15 / dim, two quotient bits per stage.
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        logic [REM_W-1:0] rem_in;
        logic [Q_W-1:0]   quo_in;
        logic             sat_in;
        logic             neg_in;
        logic [REM_W-1:0] rem_next;
        logic [Q_W-1:0]   quo_next;

        if (g == 0)
        begin : g_first
            assign rem_in = mag_reg;
            assign quo_in = '0;
            assign sat_in = sat_reg;
            assign neg_in = neg_reg;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign quo_in = quo_reg[g-1];
            assign sat_in = dsat_reg[g-1];
            assign neg_in = dneg_reg[g-1];
        end

        // Each step compares, subtracts and doubles the partial remainder.
        always_comb
        begin
            logic [REM_W-1:0] r;
            logic [REM_W-1:0] r_sub;
            logic [Q_W-1:0]   q;
            logic             b;
            r = rem_in;
            q = quo_in;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                b     = (r >= dim);
                r_sub = b ? (r - dim) : r;
                q     = {q[Q_W-2:0], b};
                r     = {r_sub[REM_W-2:0], 1'b0};
            end
            rem_next = r;
            quo_next = q;
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.en)
            begin
                rem_reg[g]  <= rem_next;
                quo_reg[g]  <= quo_next;
                dsat_reg[g] <= sat_in;
                dneg_reg[g] <= neg_in;
            end
        end
    end

    // Apply the sign and clip positions at or past the far edge.
    always_comb
    begin
        if (dsat_reg[DIV_STAGES-1])
        begin
            norm_next = NORM_W'(2**(NORM_W-1) - 1);
        end
        else if (dneg_reg[DIV_STAGES-1])
        begin
            norm_next = -quo_reg[DIV_STAGES-1];
        end
        else
        begin
            norm_next = quo_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            norm_reg <= norm_next;
        end
    end

    assign norm = norm_reg;

endmodule

/* rtl/core/rdm_scale.sv */
// Computes the radial scale factor from both normalized coordinates.
module rdm_scale (
    input  logic                                clk,
    input  rdm_pkg::pipe_ctrl_t                 ctrl,
    input  logic signed [rdm_pkg::NORM_W-1:0]   x,
    input  logic signed [rdm_pkg::NORM_W-1:0]   y,
    input  logic signed [rdm_pkg::COEF_W-1:0]   k1,
    input  logic signed [rdm_pkg::COEF_W-1:0]   k2,
    input  logic                                pincushion,
    output logic signed [rdm_pkg::SCALE_W-1:0]  scale,
    output logic signed [rdm_pkg::NORM_W-1:0]   x_out,
    output logic signed [rdm_pkg::NORM_W-1:0]   y_out
);
    import rdm_pkg::*;

    localparam logic signed [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << SCALE_FRAC;

    logic signed [2*NORM_W-1:0] xx_full;
    logic signed [2*NORM_W-1:0] yy_full;
    logic [SQ_W-1:0]            xx_reg;
    logic [SQ_W-1:0]            yy_reg;
    logic [SQ_W:0]              sq_sum;
    logic [R2_W-1:0]            r2_reg;
    logic [2*R2_W-1:0]          r2_sq;
    logic [R4_W-1:0]            r4_reg;
    logic signed [K1R2_W-1:0]   k1r2_reg;
    logic signed [K1R2_W-1:0]   k1r2_d_reg;
    logic signed [K2R4_W-1:0]   k2r4_reg;
    logic signed [SCALE_W-1:0]  poly;
    logic signed [SCALE_W-1:0]  scale_next;
    logic signed [SCALE_W-1:0]  scale_reg;

    logic signed [NORM_W-1:0] xd_reg [SCALE_LAT];
    logic signed [NORM_W-1:0] yd_reg [SCALE_LAT];

    // Squares of both coordinates; both are non-negative.
    assign xx_full = x * x;
    assign yy_full = y * y;

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            xx_reg <= xx_full[SQ_W-1:0];
            yy_reg <= yy_full[SQ_W-1:0];
        end
    end

    // Squared radius in Q2.15.
    assign sq_sum = {1'b0, xx_reg} + {1'b0, yy_reg};

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            r2_reg <= sq_sum[SQ_W:R_FRAC];
        end
    end

    // Fourth power of the radius and the first-order term.
    assign r2_sq = r2_reg * r2_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            r4_reg   <= r2_sq[R_FRAC+R4_W-1:R_FRAC];
            k1r2_reg <= K1R2_W'(k1 * $signed({1'b0, r2_reg}));
        end
    end

    // Second-order term.
    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            k2r4_reg   <= K2R4_W'(k2 * $signed({1'b0, r4_reg}));
            k1r2_d_reg <= k1r2_reg;
        end
    end

    // Polynomial and its sign convention around one.
    assign poly       = SCALE_W'(k1r2_d_reg) - SCALE_W'(k2r4_reg);
    assign scale_next = pincushion ? (SCALE_ONE + poly) : (SCALE_ONE - poly);

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            scale_reg <= scale_next;
        end
    end

    // Coordinates ride alongside so they meet their scale factor.
    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            xd_reg[0] <= x;
            yd_reg[0] <= y;
            for (int i = 1; i < SCALE_LAT; i++)
            begin
                xd_reg[i] <= xd_reg[i-1];
                yd_reg[i] <= yd_reg[i-1];
            end
        end
    end

    assign scale = scale_reg;
    assign x_out = xd_reg[SCALE_LAT-1];
    assign y_out = yd_reg[SCALE_LAT-1];

endmodule

/* rtl/core/rdm_remap.sv */
// Maps one scaled normalized coordinate back to saturated pixel units.
module rdm_remap #(
    parameter int FRAC_BITS = 4
) (
    input  logic                                clk,
    input  rdm_pkg::pipe_ctrl_t                 ctrl,
    input  logic signed [rdm_pkg::NORM_W-1:0]   v,
    input  logic signed [rdm_pkg::SCALE_W-1:0]  scale,
    input  logic [rdm_pkg::DIM_W-1:0]           dim,
    output logic signed [rdm_pkg::OUT_W-1:0]    pix,
    output logic                                clip
);
    import rdm_pkg::*;

    localparam int RND_SHIFT = HALF_EXP + 1 - FRAC_BITS;
    localparam logic signed [PROD_W-1:0] HALF_BIAS = PROD_W'(1) << HALF_EXP;
    localparam logic signed [T_W-1:0]    RND_BIAS  = T_W'(1) << (RND_SHIFT - 1);
    localparam logic signed [T_W-1:0]    PIX_MAX   = T_W'(2**(OUT_W-1) - 1);
    localparam logic signed [T_W-1:0]    PIX_MIN   = -T_W'(2**(OUT_W-1));

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [T_W-1:0]    t_reg;
    logic signed [T_W-1:0]    shifted;
    logic signed [OUT_W-1:0]  pix_next;
    logic                     clip_next;
    logic signed [OUT_W-1:0]  pix_reg;
    logic                     clip_reg;

    // Coordinate times scale.
    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            prod_reg <= PROD_W'(v * scale);
        end
    end

    // Shift from [-1,1) to [0,2) and multiply by the dimension.
    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            t_reg <= T_W'((prod_reg + HALF_BIAS) * $signed({1'b0, dim}));
        end
    end

    // Round half up, drop to the output fraction and clip to 16 bits.
    assign shifted = (t_reg + RND_BIAS) >>> RND_SHIFT;

    always_comb
    begin
        clip_next = 1'b0;
        pix_next  = shifted[OUT_W-1:0];
        if (shifted > PIX_MAX)
        begin
            pix_next  = PIX_MAX[OUT_W-1:0];
            clip_next = 1'b1;
        end
        else if (shifted < PIX_MIN)
        begin
            pix_next  = PIX_MIN[OUT_W-1:0];
            clip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            pix_reg  <= pix_next;
            clip_reg <= clip_next;
        end
    end

    assign pix  = pix_reg;
    assign clip = clip_reg;

endmodule

/* rtl/core/radial_distortion_map.sv */
// Top level of the radial lens distortion coordinate map.
//
// Takes one request per clock when not stalled (an output pixel row and
// column) and returns the source position to sample under a two-coefficient
// radial lens model, as signed fixed point with FRAC_BITS fraction bits,
// saturated with a flag. Every request yields exactly one result. The largest
// part of the depth is the normalizing divider, eight stages of two quotient
// bits each, followed by the squaring, polynomial and remap multiplier stages.
// When a finished result is not taken, the whole pipeline holds and req_ready
// drops until it moves. Configuration registers are written through cfg_we,
// cfg_idx and cfg_wdata and must only change while no request is in flight.
module radial_distortion_map #(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rdm_pkg::IDX_W-1:0]           cfg_idx,
    input  logic [rdm_pkg::DATA_W-1:0]          cfg_wdata,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic [rdm_pkg::COORD_W-1:0]         out_row,
    input  logic [rdm_pkg::COORD_W-1:0]         out_col,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic signed [rdm_pkg::OUT_W-1:0]    src_row,
    output logic signed [rdm_pkg::OUT_W-1:0]    src_col,
    output logic                                saturated
);
    import rdm_pkg::*;

    localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(MAX_DIM);

    logic [DIM_W-1:0]         image_rows_reg;
    logic [DIM_W-1:0]         image_cols_reg;
    logic signed [COEF_W-1:0] k1_coeff_reg;
    logic signed [COEF_W-1:0] k2_coeff_reg;
    logic                     pincushion_mode_reg;

    logic [DIM_W-1:0] dim_rows;
    logic [DIM_W-1:0] dim_cols;

    logic [LATENCY-1:0] valid_reg;
    logic [LATENCY-1:0] valid_next;
    pipe_ctrl_t         ctrl;

    logic signed [NORM_W-1:0]  x_norm;
    logic signed [NORM_W-1:0]  y_norm;
    logic signed [NORM_W-1:0]  x_aligned;
    logic signed [NORM_W-1:0]  y_aligned;
    logic signed [SCALE_W-1:0] scale;
    logic                      clip_row;
    logic                      clip_col;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_rows_reg      <= DIM_W'(480);
            image_cols_reg      <= DIM_W'(640);
            k1_coeff_reg        <= '0;
            k2_coeff_reg        <= '0;
            pincushion_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_IMAGE_ROWS:      image_rows_reg      <= cfg_wdata[DIM_W-1:0];
                CFG_IMAGE_COLS:      image_cols_reg      <= cfg_wdata[DIM_W-1:0];
                CFG_K1_COEFF:        k1_coeff_reg        <= cfg_wdata;
                CFG_K2_COEFF:        k2_coeff_reg        <= cfg_wdata;
                CFG_PINCUSHION_MODE: pincushion_mode_reg <= cfg_wdata[0];
                default:             ;
            endcase
        end
    end

    // Effective dimensions: zero reads as one, large values clamp to the cap.
    always_comb
    begin
        dim_rows = image_rows_reg;
        if (image_rows_reg == '0)
        begin
            dim_rows = DIM_W'(1);
        end
        else if (image_rows_reg > DIM_CAP)
        begin
            dim_rows = DIM_CAP;
        end

        dim_cols = image_cols_reg;
        if (image_cols_reg == '0)
        begin
            dim_cols = DIM_W'(1);
        end
        else if (image_cols_reg > DIM_CAP)
        begin
            dim_cols = DIM_CAP;
        end
    end

    // The pipeline advances unless a finished result is waiting to be taken.
    assign ctrl.en   = !valid_reg[LATENCY-1] || rsp_ready;
    assign req_ready = ctrl.en;

    // Valid bits travel with the data.
    assign valid_next = {valid_reg[LATENCY-2:0], req_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.en)
        begin
            valid_reg <= valid_next;
        end
    end

    // Normalization of row and column.
    rdm_normalize u_norm_row (
        .clk  (clk),
        .ctrl (ctrl),
        .pos  (out_row),
        .dim  (dim_rows),
        .norm (x_norm)
    );

    rdm_normalize u_norm_col (
        .clk  (clk),
        .ctrl (ctrl),
        .pos  (out_col),
        .dim  (dim_cols),
        .norm (y_norm)
    );

    // Radial scale factor.
    rdm_scale u_scale (
        .clk        (clk),
        .ctrl       (ctrl),
        .x          (x_norm),
        .y          (y_norm),
        .k1         (k1_coeff_reg),
        .k2         (k2_coeff_reg),
        .pincushion (pincushion_mode_reg),
        .scale      (scale),
        .x_out      (x_aligned),
        .y_out      (y_aligned)
    );

    // Back to pixel units.
    rdm_remap #(
        .FRAC_BITS (FRAC_BITS)
    ) u_remap_row (
        .clk   (clk),
        .ctrl  (ctrl),
        .v     (x_aligned),
        .scale (scale),
        .dim   (dim_rows),
        .pix   (src_row),
        .clip  (clip_row)
    );

    rdm_remap #(
        .FRAC_BITS (FRAC_BITS)
    ) u_remap_col (
        .clk   (clk),
        .ctrl  (ctrl),
        .v     (y_aligned),
        .scale (scale),
        .dim   (dim_cols),
        .pix   (src_col),
        .clip  (clip_col)
    );

    assign rsp_valid = valid_reg[LATENCY-1];
    assign saturated = clip_row | clip_col;

endmodule
